// ----- rtl/core/q22alu_pkg.sv -----
// Shared constants, codes and types for the Q22.10 fixed-point ALU.
// No dependencies; compiled first.
package q22alu_pkg;

   localparam int DATA_W       = 32;
   localparam int MODE_W       = 3;
   localparam int STAT_W       = 3;
   localparam int MAX_ITER_DEF = 32;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NEG  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SQRT = 3'd5;
   localparam logic [MODE_W-1:0] MODE_TOF  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_FRF  = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_DIV0    = 3'd1;
   localparam logic [STAT_W-1:0] ST_SAT     = 3'd2;
   localparam logic [STAT_W-1:0] ST_NEGROOT = 3'd3;
   localparam logic [STAT_W-1:0] ST_ITER    = 3'd4;

   // datapath commands
   typedef logic [3:0] cmd_code_type;
   localparam cmd_code_type CMD_NONE      = 4'd0;
   localparam cmd_code_type CMD_LOAD      = 4'd1;
   localparam cmd_code_type CMD_EXEC      = 4'd2;
   localparam cmd_code_type CMD_MUL       = 4'd3;
   localparam cmd_code_type CMD_MUL_FIN   = 4'd4;
   localparam cmd_code_type CMD_DIV_START = 4'd5;
   localparam cmd_code_type CMD_DIV_FIN   = 4'd6;
   localparam cmd_code_type CMD_SQ_INIT   = 4'd7;
   localparam cmd_code_type CMD_SQ_STEP   = 4'd8;
   localparam cmd_code_type CMD_SQ_UPD    = 4'd9;
   localparam cmd_code_type CMD_SQ_END    = 4'd10;
   localparam cmd_code_type CMD_TOF_INIT  = 4'd11;
   localparam cmd_code_type CMD_TOF_SHIFT = 4'd12;
   localparam cmd_code_type CMD_TOF_FIN   = 4'd13;

   typedef struct packed {
      cmd_code_type code;
      logic         publish;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              div_done;
      logic              div_dz;
      logic              est_eq_old;
      logic              a_neg;
      logic              a_zero;
      logic              norm_done;
   } dp_stat_type;

   typedef struct packed {
      logic done;
      logic dz;
   } div_stat_type;

endpackage

// ----- rtl/core/q22alu_if.sv -----
// Valid/ready channel interfaces for request and response transfers.
// Depends on q22alu_pkg for field widths.
interface q22alu_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [q22alu_pkg::MODE_W-1:0]    mode;
   logic signed [q22alu_pkg::DATA_W-1:0]    operand_a;
   logic signed [q22alu_pkg::DATA_W-1:0]    operand_b;
   modport source (output valid, mode, operand_a, operand_b, input ready);
   modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface q22alu_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [q22alu_pkg::DATA_W-1:0]    result;
   logic        [q22alu_pkg::STAT_W-1:0]    status;
   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface

// ----- rtl/core/q22alu_div.sv -----
// Bit-serial signed divider: (a / (b >>> 5)) << 5, truncating toward zero.
// Depends on q22alu_pkg.
module q22alu_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [q22alu_pkg::DATA_W-1:0] dividend,
   input  logic signed [q22alu_pkg::DATA_W-1:0] divisor,
   output q22alu_pkg::div_stat_type             stat,
   output logic        [q22alu_pkg::DATA_W-1:0] quot_fx
);
   import q22alu_pkg::*;

   logic signed [DATA_W-1:0] d_full;
   logic        [DATA_W-1:0] d_abs, a_abs, q_signed;
   logic        [28:0]       diff;
   logic        [26:0]       rem_ff, rem_in, dmag_ff, dmag_in;
   logic        [31:0]       quo_ff, quo_in;
   logic        [5:0]        cnt_ff, cnt_in;
   logic                     neg_ff, neg_in, done_ff, done_in, dz_ff, dz_in;

   always_comb begin
      d_full  = divisor >>> 5;
      d_abs   = d_full[DATA_W-1] ? (~d_full + 1'b1) : d_full;
      a_abs   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      diff    = {1'b0, rem_ff, quo_ff[31]} - {2'b0, dmag_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dz_in   = dz_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = a_abs;
         dmag_in = d_abs[26:0];
         neg_in  = dividend[DATA_W-1] ^ d_full[DATA_W-1];
         dz_in   = (d_full == '0);
         if (d_full == '0) begin
            done_in = 1'b1;
            cnt_in  = '0;
         end else begin
            cnt_in  = 6'd32;
         end
      end else if (cnt_ff != '0) begin
         if (!diff[28]) begin
            rem_in = diff[26:0];
         end else begin
            rem_in = {rem_ff[25:0], quo_ff[31]};
         end
         quo_in  = {quo_ff[30:0], ~diff[28]};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         dz_ff   <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         dz_ff   <= dz_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign q_signed  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign quot_fx   = {q_signed[26:0], 5'b0};
   assign stat.done = done_ff;
   assign stat.dz   = dz_ff;

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for two cycles");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> cnt_ff == '0)
      else $error("divider started while busy");
   a_dz_fast: assert property (@(posedge clock) disable iff (reset)
      start && (d_full == '0) |=> done_ff && dz_ff)
      else $error("zero divisor not reported next cycle");

endmodule

// ----- rtl/core/q22alu_dp.sv -----
// Datapath: operand registers, multiplier, divider, normaliser, result registers.
// Depends on q22alu_pkg and q22alu_div.
module q22alu_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  q22alu_pkg::dp_cmd_type               cmd,
   input  logic        [q22alu_pkg::MODE_W-1:0] in_mode,
   input  logic signed [q22alu_pkg::DATA_W-1:0] in_a,
   input  logic signed [q22alu_pkg::DATA_W-1:0] in_b,
   output q22alu_pkg::dp_stat_type              stat,
   output logic signed [q22alu_pkg::DATA_W-1:0] out_result,
   output logic        [q22alu_pkg::STAT_W-1:0] out_status
);
   import q22alu_pkg::*;

   logic        [MODE_W-1:0]   mode_ff, mode_in;
   logic signed [DATA_W-1:0]   a_ff, a_in, b_ff, b_in, est_ff, est_in, old_ff, old_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic        [DATA_W-1:0]   mag_ff, mag_in, res_ff, res_in, ores_ff, ores_in;
   logic        [4:0]          pos_ff, pos_in;
   logic        [STAT_W-1:0]   st_ff, st_in, ost_ff, ost_in;

   div_stat_type              dstat;
   logic                      div_start;
   logic signed [DATA_W-1:0]  div_den, sum, qs;
   logic        [DATA_W-1:0]  div_q, nxt, exec_res, ff_res;
   logic        [STAT_W-1:0]  exec_st, ff_st;
   logic        [7:0]         e, sh;
   logic        [23:0]        mant;
   logic        [32:0]        up, lim;

   assign div_start = (cmd.code == CMD_DIV_START) || (cmd.code == CMD_SQ_STEP);
   assign div_den   = (cmd.code == CMD_SQ_STEP) ? est_ff : b_ff;

   q22alu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (div_den),
      .stat     (dstat),
      .quot_fx  (div_q)
   );

   // from_float conversion
   always_comb begin
      e     = a_ff[30:23];
      mant  = {1'b1, a_ff[22:0]};
      ff_res = '0;
      ff_st  = ST_OK;
      sh    = '0;
      up    = '0;
      lim   = a_ff[31] ? 33'h080000000 : 33'h07FFFFFFF;
      if (e == 8'd0 || e == 8'd255) begin
         ff_res = '0;
      end else if (e >= 8'd140) begin
         sh = e - 8'd140;
         up = {9'b0, mant} << sh[3:0];
         if (sh > 8'd8 || up > lim) begin
            ff_st  = ST_SAT;
            ff_res = a_ff[31] ? 32'h80000000 : 32'h7FFFFFFF;
         end else begin
            ff_res = a_ff[31] ? (~up[31:0] + 1'b1) : up[31:0];
         end
      end else begin
         sh = 8'd140 - e;
         if (sh >= 8'd32) begin
            ff_res = '0;
         end else begin
            up[31:0] = {8'b0, mant} >> sh[4:0];
            ff_res   = a_ff[31] ? (~up[31:0] + 1'b1) : up[31:0];
         end
      end
   end

   // operations finished by the EXEC command
   always_comb begin
      exec_st = ST_OK;
      unique case (mode_ff)
         MODE_ADD:  exec_res = a_ff + b_ff;
         MODE_SUB:  exec_res = a_ff - b_ff;
         MODE_NEG:  exec_res = '0 - a_ff;
         MODE_SQRT: begin
            exec_res = '0;
            exec_st  = ST_NEGROOT;
         end
         MODE_FRF: begin
            exec_res = ff_res;
            exec_st  = ff_st;
         end
         default:   exec_res = '0;
      endcase
   end

   // est + a/est, then halve it: divide by 64 toward zero, then shift left by 5
   always_comb begin
      sum = est_ff + div_q;
      qs  = (sum + (sum[DATA_W-1] ? 32'sd63 : 32'sd0)) >>> 6;
      nxt = {qs[26:0], 5'b0};
   end

   always_comb begin
      mode_in = mode_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      est_in  = est_ff;
      old_in  = old_ff;
      mag_in  = mag_ff;
      pos_in  = pos_ff;
      res_in  = res_ff;
      st_in   = st_ff;
      ores_in = ores_ff;
      ost_in  = ost_ff;
      unique case (cmd.code)
         CMD_LOAD: begin
            mode_in = in_mode;
            a_in    = in_a;
            b_in    = in_b;
         end
         CMD_EXEC: begin
            res_in = exec_res;
            st_in  = exec_st;
         end
         CMD_MUL:     prod_in = a_ff * b_ff;
         CMD_MUL_FIN: begin
            res_in = prod_ff[41:10];
            st_in  = ST_OK;
         end
         CMD_DIV_FIN: begin
            res_in = dstat.dz ? '0 : div_q;
            st_in  = dstat.dz ? ST_DIV0 : ST_OK;
         end
         CMD_SQ_INIT: begin
            est_in = a_ff >>> 1;
            old_in = '0;
         end
         CMD_SQ_STEP: old_in = est_ff;
         CMD_SQ_UPD:  est_in = nxt;
         CMD_SQ_END: begin
            res_in = est_ff;
            st_in  = (est_ff == old_ff) ? ST_OK : ST_ITER;
         end
         CMD_TOF_INIT: begin
            mag_in = a_ff[DATA_W-1] ? (~a_ff + 1'b1) : a_ff;
            pos_in = 5'd31;
         end
         CMD_TOF_SHIFT: begin
            mag_in = {mag_ff[30:0], 1'b0};
            pos_in = pos_ff - 5'd1;
         end
         CMD_TOF_FIN: begin
            res_in = {a_ff[DATA_W-1], {3'b0, pos_ff} + 8'd117, mag_ff[30:8]};
            st_in  = ST_OK;
         end
         default: ;
      endcase
      if (cmd.publish) begin
         ores_in = res_ff;
         ost_in  = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      est_ff  <= est_in;
      old_ff  <= old_in;
      mag_ff  <= mag_in;
      pos_ff  <= pos_in;
      res_ff  <= res_in;
      st_ff   <= st_in;
      ores_ff <= ores_in;
      ost_ff  <= ost_in;
   end

   assign stat.mode       = mode_ff;
   assign stat.div_done   = dstat.done;
   assign stat.div_dz     = dstat.dz;
   assign stat.est_eq_old = (est_ff == old_ff);
   assign stat.a_neg      = a_ff[DATA_W-1];
   assign stat.a_zero     = (a_ff == '0);
   assign stat.norm_done  = mag_ff[31] || (pos_ff == '0);
   assign out_result      = ores_ff;
   assign out_status      = ost_ff;

endmodule

// ----- rtl/core/q22alu_ctrl.sv -----
// Controller state machine sequencing the datapath and owning both handshakes.
// Depends on q22alu_pkg.
module q22alu_ctrl #(
   parameter int MAX_ITER = q22alu_pkg::MAX_ITER_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  q22alu_pkg::dp_stat_type stat,
   output q22alu_pkg::dp_cmd_type  cmd
);
   import q22alu_pkg::*;

   localparam int ITER_W = $clog2(MAX_ITER + 1);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITER);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_MULF  = 4'd2;
   localparam logic [3:0] S_DIVW  = 4'd3;
   localparam logic [3:0] S_NORM  = 4'd4;
   localparam logic [3:0] S_SQCHK = 4'd5;
   localparam logic [3:0] S_SQW   = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   logic [3:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              ovalid_ff, ovalid_in;
   logic              slot_free, accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !ovalid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      cmd.code    = CMD_NONE;
      cmd.publish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.code = CMD_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.mode)
               MODE_MUL: begin
                  cmd.code = CMD_MUL;
                  state_in = S_MULF;
               end
               MODE_DIV: begin
                  cmd.code = CMD_DIV_START;
                  state_in = S_DIVW;
               end
               MODE_SQRT: begin
                  if (stat.a_neg) begin
                     cmd.code = CMD_EXEC;
                     state_in = S_DONE;
                  end else begin
                     cmd.code = CMD_SQ_INIT;
                     iter_in  = '0;
                     state_in = S_SQCHK;
                  end
               end
               MODE_TOF: begin
                  if (stat.a_zero) begin
                     cmd.code = CMD_EXEC;
                     state_in = S_DONE;
                  end else begin
                     cmd.code = CMD_TOF_INIT;
                     state_in = S_NORM;
                  end
               end
               default: begin
                  cmd.code = CMD_EXEC;
                  state_in = S_DONE;
               end
            endcase
         end
         S_MULF: begin
            cmd.code = CMD_MUL_FIN;
            state_in = S_DONE;
         end
         S_DIVW: begin
            if (stat.div_done) begin
               cmd.code = CMD_DIV_FIN;
               state_in = S_DONE;
            end
         end
         S_NORM: begin
            if (stat.norm_done) begin
               cmd.code = CMD_TOF_FIN;
               state_in = S_DONE;
            end else begin
               cmd.code = CMD_TOF_SHIFT;
            end
         end
         S_SQCHK: begin
            if (iter_ff == ITER_LAST || stat.est_eq_old) begin
               cmd.code = CMD_SQ_END;
               state_in = S_DONE;
            end else begin
               cmd.code = CMD_SQ_STEP;
               iter_in  = iter_ff + 1'b1;
               state_in = S_SQW;
            end
         end
         S_SQW: begin
            if (stat.div_done) begin
               // a zero divisor ends the root with the fault result
               cmd.code = stat.div_dz ? CMD_DIV_FIN : CMD_SQ_UPD;
               state_in = stat.div_dz ? S_DONE : S_SQCHK;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ovalid_in = ovalid_ff;
      if (cmd.publish) begin
         ovalid_in = 1'b1;
      end else if (rsp_ready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         iter_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         iter_ff   <= iter_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_valid = ovalid_ff;

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_LAST)
      else $error("root iteration count beyond limit");
   a_publish: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && slot_free |=> ovalid_ff && state_ff == S_IDLE)
      else $error("finished result not placed in output register");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DISP)
      else $error("accepted request not dispatched");

endmodule

// ----- rtl/core/q22_10_fixed_point_alu.sv -----
// Top level of the Q22.10 fixed-point ALU: controller plus datapath.
// Depends on q22alu_pkg, q22alu_if, q22alu_ctrl, q22alu_dp.
//
//   channel   | dir | payload                          | handshake
//   req_chan  | in  | mode, operand_a, operand_b       | valid/ready
//   rsp_chan  | out | result, status                   | valid/ready
//
// One request at a time. add/sub/neg/from_float finish with one EXEC command,
// mul with a multiply then a scaling step, div in the 32-step bit-serial divider,
// to_float with one normalising shift per cycle, sqrt in up to MAX_ITER rounds.
// Synchronous active-high reset clears control only. A stalled response holds
// in the output register; the next request is taken meanwhile.
module q22_10_fixed_point_alu #(
   parameter int MAX_ITER = q22alu_pkg::MAX_ITER_DEF
) (
   input logic          clock,
   input logic          reset,
   q22alu_req_if.sink   req_chan,
   q22alu_rsp_if.source rsp_chan
);
   import q22alu_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   q22alu_ctrl #(
      .MAX_ITER (MAX_ITER)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   q22alu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_mode    (req_chan.mode),
      .in_a       (req_chan.operand_a),
      .in_b       (req_chan.operand_b),
      .stat       (stat),
      .out_result (rsp_chan.result),
      .out_status (rsp_chan.status)
   );

endmodule
